[rtl/cmf_pkg.sv]
// Shared types and constants for the complex matched filter magnitude block.
`timescale 1ns / 1ps

package cmf_pkg;

	// Fixed field widths
	localparam int CMD_W  = 2;
	localparam int TIDX_W = 10;
	localparam int TC_W   = 11;
	localparam int MAG_W  = 42;
	localparam int WS_W   = 32;
	localparam int OUT_W  = 80;

	localparam logic [TC_W-1:0] TC_RESET = 11'd1024;

	// Input item kinds carried on tuser
	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr_step;
		logic tap_load;
		logic push;
		logic restart;
		logic mac_issue;
		logic sq_load_re;
		logic sq_load_im;
		logic sq_step;
		logic rt_load;
		logic rt_step;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic win_full;
		logic mac_last;
		logic pipe_busy;
		logic sq_last;
		logic rt_last;
		logic out_full;
	} sts_t;

endpackage

[rtl/cmf_ctrl.sv]
// Controller state machine for the complex matched filter magnitude block.
`timescale 1ns / 1ps

module cmf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [cmf_pkg::CMD_W-1:0] in_command,
	output logic                      in_ready,
	input  cmf_pkg::sts_t             sts,
	output cmf_pkg::cmd_t             cmd
);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MAC   = 4'd2;
	localparam logic [3:0] ST_DRAIN = 4'd3;
	localparam logic [3:0] ST_SQR   = 4'd4;
	localparam logic [3:0] ST_SQI   = 4'd5;
	localparam logic [3:0] ST_RLOAD = 4'd6;
	localparam logic [3:0] ST_ROOT  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Decode state into datapath commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_command)
						cmf_pkg::CMD_LOAD: begin
							cmd.tap_load = 1'b1;
						end
						cmf_pkg::CMD_PUSH: begin
							cmd.push = 1'b1;
							if (sts.win_full) begin
								state_d = ST_MAC;
							end
						end
						cmf_pkg::CMD_RESTART: begin
							cmd.restart = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (sts.mac_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.sq_load_re = 1'b1;
					state_d        = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last) begin
					cmd.sq_load_im = 1'b1;
					state_d        = ST_SQI;
				end
			end
			ST_SQI: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last) begin
					state_d = ST_RLOAD;
				end
			end
			ST_RLOAD: begin
				cmd.rt_load = 1'b1;
				state_d     = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.rt_step = 1'b1;
				if (sts.rt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/cmf_datapath.sv]
// Datapath: tap and sample memories, complex MAC, serial square sum, square root.
`timescale 1ns / 1ps

module cmf_datapath #(
	parameter int MAX_TAPS    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int IN_W        = 80
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmf_pkg::cmd_t              cmd,
	output cmf_pkg::sts_t              sts,
	input  logic [IN_W-1:0]            in_data,
	input  logic                       cfg_we,
	input  logic [cmf_pkg::TC_W-1:0]   cfg_wdata,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [cmf_pkg::MAG_W-1:0]  out_mag,
	output logic [cmf_pkg::WS_W-1:0]   out_ws
);

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(MAX_TAPS);
	localparam int LW    = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = 2 * SB + 1 + $clog2(MAX_TAPS);
	localparam int SQ_W  = 2 * ACC_W + 1;
	localparam int RT_W  = ACC_W + 1;
	localparam int RAD_W = 2 * RT_W;
	localparam int REM_W = RT_W + 3;
	localparam int IW    = $clog2(RT_W + 1);
	localparam int TI    = cmf_pkg::TIDX_W;

	// Payload fields
	logic [TI-1:0] f_idx;
	logic [SB-1:0] f_tre, f_tim, f_sre, f_sim;
	assign f_idx = in_data[TI-1:0];
	assign f_tre = in_data[TI +: SB];
	assign f_tim = in_data[TI + SB +: SB];
	assign f_sre = in_data[TI + 2 * SB +: SB];
	assign f_sim = in_data[TI + 3 * SB +: SB];

	// Configuration and window state
	logic [cmf_pkg::TC_W-1:0] tc_q;
	logic [LW-1:0]            len_c, len_q;
	logic [AW-1:0]            lp_q, lp_next, slot_q, slot_start, clr_q;
	logic [31:0]              seen_q, seen_inc, lpn32;
	logic [LW-1:0]            p_q;

	// Clamp window length into 1..MAX_TAPS
	always_comb begin
		if (tc_q == '0) begin
			len_c = LW'(1);
		end else if (32'(tc_q) > 32'(MAX_TAPS)) begin
			len_c = LW'(MAX_TAPS);
		end else begin
			len_c = LW'(tc_q);
		end
	end

	assign lp_next  = (lp_q == AW'(MAX_TAPS - 1)) ? '0 : lp_q + 1'b1;
	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 32'd1;
	assign lpn32    = 32'(lp_next);

	// Oldest slot of the window after this push
	always_comb begin
		if (lpn32 >= 32'(len_c)) begin
			slot_start = AW'(lpn32 - 32'(len_c));
		end else begin
			slot_start = AW'(lpn32 + 32'(MAX_TAPS) - 32'(len_c));
		end
	end

	// Tap store write port: clearing pass or tap load
	logic          tap_we;
	logic [AW-1:0] tap_waddr;
	logic [2*SB-1:0] tap_wdata;
	always_comb begin
		tap_we    = 1'b0;
		tap_waddr = clr_q;
		tap_wdata = '0;
		if (cmd.clr_step) begin
			tap_we = 1'b1;
		end else if (cmd.tap_load && (32'(f_idx) < 32'(MAX_TAPS))) begin
			tap_we    = 1'b1;
			tap_waddr = AW'(f_idx);
			tap_wdata = {f_tim, f_tre};
		end
	end

	logic [2*SB-1:0] tap_mem [MAX_TAPS];
	logic [2*SB-1:0] line_mem [MAX_TAPS];
	logic [2*SB-1:0] tap_rd_s1, ln_rd_s1;

	// Memories with registered reads
	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_waddr] <= tap_wdata;
		end
		tap_rd_s1 <= tap_mem[p_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			line_mem[lp_q] <= {f_sim, f_sre};
		end
		ln_rd_s1 <= line_mem[slot_q];
	end

	// Control registers of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q   <= cmf_pkg::TC_RESET;
			clr_q  <= '0;
			lp_q   <= '0;
			seen_q <= '0;
			p_q    <= '0;
		end else begin
			if (cfg_we) begin
				tc_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.restart) begin
				lp_q   <= '0;
				seen_q <= '0;
			end else if (cmd.push) begin
				lp_q   <= lp_next;
				seen_q <= seen_inc;
			end
			if (cmd.push) begin
				p_q <= '0;
			end else if (cmd.mac_issue) begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	// Window length and walking slot
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			len_q  <= len_c;
			slot_q <= slot_start;
		end else if (cmd.mac_issue) begin
			slot_q <= (slot_q == AW'(MAX_TAPS - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// MAC pipeline valid bits
	logic v_s1, v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	// Multiply stage
	logic signed [SB-1:0]   xr, xi, tr, ti;
	logic signed [2*SB-1:0] prr_s2, pii_s2, pir_s2, pri_s2;
	assign xr = $signed(ln_rd_s1[SB-1:0]);
	assign xi = $signed(ln_rd_s1[2*SB-1:SB]);
	assign tr = $signed(tap_rd_s1[SB-1:0]);
	assign ti = $signed(tap_rd_s1[2*SB-1:SB]);

	always_ff @(posedge clk) begin
		prr_s2 <= xr * tr;
		pii_s2 <= xi * ti;
		pir_s2 <= xi * tr;
		pri_s2 <= xr * ti;
	end

	// Accumulate x times conjugate tap
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(prr_s2) + ACC_W'(pii_s2);
			acc_im_q <= acc_im_q + ACC_W'(pir_s2) - ACC_W'(pri_s2);
		end
	end

	logic [ACC_W-1:0] abs_re, abs_im;
	assign abs_re = acc_re_q[ACC_W-1] ? ACC_W'(-acc_re_q) : ACC_W'(acc_re_q);
	assign abs_im = acc_im_q[ACC_W-1] ? ACC_W'(-acc_im_q) : ACC_W'(acc_im_q);

	// Shift-add squaring of both parts into one sum
	logic [ACC_W-1:0] m_q;
	logic [SQ_W-1:0]  sh_q, sum_q;
	logic [IW-1:0]    it_q;
	always_ff @(posedge clk) begin
		if (cmd.sq_load_re) begin
			sum_q <= '0;
		end else if (cmd.sq_step) begin
			sum_q <= sum_q + (m_q[0] ? sh_q : '0);
		end
		if (cmd.sq_load_re) begin
			m_q  <= abs_re;
			sh_q <= SQ_W'(abs_re);
		end else if (cmd.sq_load_im) begin
			m_q  <= abs_im;
			sh_q <= SQ_W'(abs_im);
		end else if (cmd.sq_step) begin
			m_q  <= m_q >> 1;
			sh_q <= sh_q << 1;
		end
	end

	// Restoring square root, one result bit per step
	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  root_q;
	logic [REM_W-1:0] rem_q, rem_sh, trial;
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.rt_load) begin
			rad_q  <= RAD_W'(sum_q);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.rt_step) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RT_W-2:0], 1'b0};
			end
		end
	end

	// Shared step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (cmd.sq_load_re || cmd.sq_load_im || cmd.rt_load) begin
			it_q <= '0;
		end else if (cmd.sq_step || cmd.rt_step) begin
			it_q <= it_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_mag <= cmf_pkg::MAG_W'(root_q);
			out_ws  <= seen_q - 32'(len_q);
		end
	end

	// Status back to the controller
	always_comb begin
		sts.clr_last  = (clr_q == AW'(MAX_TAPS - 1));
		sts.win_full  = (seen_inc >= 32'(len_c));
		sts.mac_last  = (p_q == LW'(len_q - LW'(1)));
		sts.pipe_busy = v_s1 | v_s2;
		sts.sq_last   = (it_q == IW'(ACC_W - 1));
		sts.rt_last   = (it_q == IW'(RT_W - 1));
		sts.out_full  = out_valid & ~out_ready;
	end

endmodule

[rtl/complex_matched_filter_magnitude.sv]
// Top level of the complex matched filter magnitude block.
`timescale 1ns / 1ps
//
// Sliding complex correlation of a sample stream against a stored probe pulse,
// returning floor(sqrt(re^2 + im^2)) of each full window sum.
// Input channel s_axis: tuser carries the command (load tap, push sample,
// restart window), tdata the tap index, tap value and sample value.
// Output channel m_axis: one transfer per sample that completes a window,
// carrying the magnitude and the index of the window's first sample.
// cfg_we/cfg_wdata write tap_count, the window length; write it only while idle.
// Load, restart and pushes that do not fill a window are each taken in the idle state.
// A push that fills a window holds off new transfers until its result is loaded: one shared
// complex multiply-accumulate walks the taps one per cycle through the tap and sample
// memories, then a shift-add squarer and a bit-serial square root finish.
// After reset the whole tap store is cleared before the first transfer is taken;
// configuration writes are taken during that time.
// A result waits in the output register while the next items are taken; only
// the next result waits if the receiver still stalls.

module complex_matched_filter_magnitude #(
	parameter int MAX_TAPS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// tap_index, tap_re, tap_im, sample_re, sample_im
	input  logic [((10 + 4 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// command
	input  logic [cmf_pkg::CMD_W-1:0]                  s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// magnitude, window_start
	output logic [cmf_pkg::OUT_W-1:0]                  m_axis_tdata,
	input  logic                                       cfg_we,
	input  logic [cmf_pkg::TC_W-1:0]                   cfg_wdata
);

	localparam int IN_W  = ((10 + 4 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int PAD_W = cmf_pkg::OUT_W - cmf_pkg::MAG_W - cmf_pkg::WS_W;

	cmf_pkg::cmd_t cmd;
	cmf_pkg::sts_t sts;
	logic [cmf_pkg::MAG_W-1:0] out_mag;
	logic [cmf_pkg::WS_W-1:0]  out_ws;

	cmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	cmf_datapath #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IN_W        (IN_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_mag   (out_mag),
		.out_ws    (out_ws)
	);

	// Pack result fields, lowest first
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_ws, out_mag};

endmodule
